@@ sv/nifd_pkg.sv @@
// Package for the NEC infrared frame decoder: register indexes, result kinds,
// frame geometry and reset values. No dependencies.
`default_nettype none

package nifd_pkg;

  localparam int DURATION_WIDTH     = 15;
  localparam int FULL_FRAME_SYMBOLS = 34;
  localparam int REPEAT_SYMBOLS     = 2;
  localparam int HALF_BITS          = 16;
  localparam int DATA_BITS          = 2 * HALF_BITS;
  localparam int COUNT_LIMIT        = 35;
  localparam int COUNT_W            = $clog2(COUNT_LIMIT + 1);
  localparam int BIT_IDX_W          = $clog2(DATA_BITS);
  localparam int NUM_REGS           = 8;
  localparam int REG_IDX_W          = $clog2(NUM_REGS);

  // Reset values of the timing registers, in receiver ticks
  localparam int RST_LEADER_MARK  = 9000;
  localparam int RST_LEADER_SPACE = 4500;
  localparam int RST_REPEAT_MARK  = 9000;
  localparam int RST_REPEAT_SPACE = 2250;
  localparam int RST_BIT_MARK     = 560;
  localparam int RST_ZERO_SPACE   = 560;
  localparam int RST_ONE_SPACE    = 1690;
  localparam int RST_TOLERANCE    = 200;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_REPEAT_MARK  = 3'd2,
    REG_REPEAT_SPACE = 3'd3,
    REG_BIT_MARK     = 3'd4,
    REG_ZERO_SPACE   = 3'd5,
    REG_ONE_SPACE    = 3'd6,
    REG_TOLERANCE    = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_FULL   = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_REJECT = 2'd2
  } frame_kind_e;

endpackage

`default_nettype wire

@@ sv/nec_ir_frame_decoder_core.sv @@
// NEC infrared frame decoder, top level: symbol input register, timing checks,
// frame state and result register. Depends on nifd_pkg.
`default_nettype none
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+-------------------------------------
//  in      | sink      | in_valid_i / in_stall_o     | mark_ticks_i, space_ticks_i,
//          |           |                             | frame_end_i
//  out     | source    | out_valid_o / out_stall_i   | frame_kind_o, address_o, command_o
//  cfg     | sink      | cfg_we_i (no back-pressure) | cfg_idx_i, cfg_data_i
//
//  Cycles: one symbol per clock, sustained unless a frame-end symbol waits (see Stalls).
//  A symbol lands in the input register, is checked and folded into the frame state in
//  the following cycle unless it waits; a frame-end symbol's result goes to the output register.
//  The timing compares (one add and compare per bound) set the critical path.
//  Reset: clears frame state, stored codes and both valid flags; timing registers
//  return to their NEC defaults.
//  Stalls: a frame-end symbol waits in the input register only while an earlier
//  result is still held by out_stall_i; symbols that give no result never wait.

module nec_ir_frame_decoder_core
  import nifd_pkg::*;
#(
  parameter int DurW = DURATION_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DurW-1:0]      cfg_data_i,
  // symbol input
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [DurW-1:0]      mark_ticks_i,
  input  wire logic [DurW-1:0]      space_ticks_i,
  input  wire logic                 frame_end_i,
  // frame results
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                frame_kind_o,
  output logic [HALF_BITS-1:0]      address_o,
  output logic [HALF_BITS-1:0]      command_o
);

  // ---------------------------------------------------------------------------
  // Timing registers
  // ---------------------------------------------------------------------------
  logic [DurW-1:0] leader_mark_q, leader_space_q, repeat_mark_q, repeat_space_q;
  logic [DurW-1:0] bit_mark_q, zero_space_q, one_space_q, tolerance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_mark_q  <= DurW'(RST_LEADER_MARK);
      leader_space_q <= DurW'(RST_LEADER_SPACE);
      repeat_mark_q  <= DurW'(RST_REPEAT_MARK);
      repeat_space_q <= DurW'(RST_REPEAT_SPACE);
      bit_mark_q     <= DurW'(RST_BIT_MARK);
      zero_space_q   <= DurW'(RST_ZERO_SPACE);
      one_space_q    <= DurW'(RST_ONE_SPACE);
      tolerance_q    <= DurW'(RST_TOLERANCE);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LEADER_MARK:  leader_mark_q  <= cfg_data_i;
        REG_LEADER_SPACE: leader_space_q <= cfg_data_i;
        REG_REPEAT_MARK:  repeat_mark_q  <= cfg_data_i;
        REG_REPEAT_SPACE: repeat_space_q <= cfg_data_i;
        REG_BIT_MARK:     bit_mark_q     <= cfg_data_i;
        REG_ZERO_SPACE:   zero_space_q   <= cfg_data_i;
        REG_ONE_SPACE:    one_space_q    <= cfg_data_i;
        REG_TOLERANCE:    tolerance_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic            s1_valid_q;
  logic [DurW-1:0] s1_mark_q, s1_space_q;
  logic            s1_last_q;
  logic            out_valid_q;
  logic            advance;
  logic            in_take;

  // A symbol moves on unless it carries a result and the output is still held
  assign advance    = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mark_q  <= mark_ticks_i;
      s1_space_q <= space_ticks_i;
      s1_last_q  <= frame_end_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Timing checks: strict window either side, widened by one bit so nothing wraps
  // ---------------------------------------------------------------------------
  function automatic logic fits(input logic [DurW-1:0] d, input logic [DurW-1:0] e,
                                input logic [DurW-1:0] tol);
    logic [DurW:0] upper;
    logic [DurW:0] d_up;
    upper = {1'b0, e} + {1'b0, tol};
    d_up  = {1'b0, d} + {1'b0, tol};
    return ({1'b0, d} < upper) && (d_up > {1'b0, e});
  endfunction

  logic leader_ok, repeat_ok, one_ok, zero_ok;

  assign leader_ok = fits(s1_mark_q, leader_mark_q, tolerance_q)
                  && fits(s1_space_q, leader_space_q, tolerance_q);
  assign repeat_ok = fits(s1_mark_q, repeat_mark_q, tolerance_q)
                  && fits(s1_space_q, repeat_space_q, tolerance_q);
  assign one_ok    = fits(s1_mark_q, bit_mark_q, tolerance_q)
                  && fits(s1_space_q, one_space_q, tolerance_q);
  assign zero_ok   = fits(s1_mark_q, bit_mark_q, tolerance_q)
                  && fits(s1_space_q, zero_space_q, tolerance_q);

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 fault_q, fault_d;
  logic                 repeat_q, repeat_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic [HALF_BITS-1:0] kept_addr_q, kept_addr_d;
  logic [HALF_BITS-1:0] kept_cmd_q, kept_cmd_d;
  logic [BIT_IDX_W-1:0] bit_idx;
  frame_kind_e          kind_d;

  assign bit_idx = BIT_IDX_W'(count_q - COUNT_W'(1));

  always_comb begin
    fault_d     = fault_q;
    repeat_d    = repeat_q;
    shift_d     = shift_q;
    kept_addr_d = kept_addr_q;
    kept_cmd_d  = kept_cmd_q;
    kind_d      = KIND_REJECT;

    // Check this symbol against the timing for its place in the frame
    if (count_q == '0) begin
      if (!leader_ok) begin
        fault_d = 1'b1;
      end
      repeat_d = repeat_ok;
    end else if (count_q <= COUNT_W'(DATA_BITS)) begin
      // A bit that fits both timings counts as a one
      priority if (one_ok) begin
        shift_d[bit_idx] = 1'b1;
      end else if (zero_ok) begin
        shift_d[bit_idx] = 1'b0;
      end else begin
        fault_d = 1'b1;
      end
    end

    count_d = (count_q < COUNT_W'(COUNT_LIMIT)) ? count_q + COUNT_W'(1) : count_q;

    // Classify the frame on its last symbol
    priority if (count_d == COUNT_W'(FULL_FRAME_SYMBOLS) && !fault_d) begin
      kept_addr_d = shift_d[HALF_BITS-1:0];
      kept_cmd_d  = shift_d[DATA_BITS-1:HALF_BITS];
      kind_d      = KIND_FULL;
    end else if (count_d == COUNT_W'(REPEAT_SYMBOLS) && repeat_d) begin
      kind_d = KIND_REPEAT;
    end else begin
      kind_d = KIND_REJECT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fault_q     <= 1'b0;
      repeat_q    <= 1'b0;
      shift_q     <= '0;
      kept_addr_q <= '0;
      kept_cmd_q  <= '0;
    end else if (advance) begin
      if (s1_last_q) begin
        // Frame done: keep the codes, clear the frame for the next one
        kept_addr_q <= kept_addr_d;
        kept_cmd_q  <= kept_cmd_d;
        count_q     <= '0;
        fault_q     <= 1'b0;
        repeat_q    <= 1'b0;
        shift_q     <= '0;
      end else begin
        count_q  <= count_d;
        fault_q  <= fault_d;
        repeat_q <= repeat_d;
        shift_q  <= shift_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  frame_kind_e          kind_q;
  logic [HALF_BITS-1:0] addr_q, cmd_q;
  logic                 load_result;

  assign load_result = advance && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_result) begin
      kind_q <= kind_d;
      addr_q <= kept_addr_d;
      cmd_q  <= kept_cmd_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_kind_o = kind_q;
  assign address_o    = addr_q;
  assign command_o    = cmd_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(COUNT_LIMIT))
    else $error("symbol count beyond saturation limit");

  a_frame_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_result |=> (count_q == '0) && !fault_q && !repeat_q && (shift_q == '0))
    else $error("frame state not cleared after frame end");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q && out_stall_i)
    else $error("input stalled without a held result");

  a_full_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_FULL) && !load_result && !$past(load_result)
      |-> (addr_q == kept_addr_q) && (cmd_q == kept_cmd_q))
    else $error("decoded codes differ from stored codes");

  a_fault_needs_symbol : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |-> count_q != '0)
    else $error("frame fault set with no symbol seen");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for nec_ir_frame_decoder_core: IR symbol streams under several
// timing settings, with a frame predictor and result checker. Needs nifd_pkg.

module testbench;
  import nifd_pkg::*;

  localparam int DW            = DURATION_WIDTH;
  localparam int DMAX          = (1 << DW) - 1;
  localparam int SETTLE        = 6;    // cycles for a symbol still in flight to land
  localparam int CHOKE_CYCLES  = 400;  // long receiver hold-off
  localparam int PHASE_SYMBOLS = 235;

  typedef logic [DW-1:0] dur_t;

  typedef struct packed {
    frame_kind_e          kind;
    logic [HALF_BITS-1:0] address;
    logic [HALF_BITS-1:0] command;
  } frame_report_t;

  // Tracks frame state from accepted symbols and holds the frame reports still due.
  class frame_tracker;
    dur_t                 timing [NUM_REGS];
    int                   count;
    bit                   fault;
    bit                   repeat_hit;
    logic [DATA_BITS-1:0] bits;
    logic [HALF_BITS-1:0] kept_address;
    logic [HALF_BITS-1:0] kept_command;
    frame_report_t        frames_due [$];
    int                   mismatches;

    function new();
      timing[REG_LEADER_MARK]  = dur_t'(RST_LEADER_MARK);
      timing[REG_LEADER_SPACE] = dur_t'(RST_LEADER_SPACE);
      timing[REG_REPEAT_MARK]  = dur_t'(RST_REPEAT_MARK);
      timing[REG_REPEAT_SPACE] = dur_t'(RST_REPEAT_SPACE);
      timing[REG_BIT_MARK]     = dur_t'(RST_BIT_MARK);
      timing[REG_ZERO_SPACE]   = dur_t'(RST_ZERO_SPACE);
      timing[REG_ONE_SPACE]    = dur_t'(RST_ONE_SPACE);
      timing[REG_TOLERANCE]    = dur_t'(RST_TOLERANCE);
      count        = 0;
      fault        = 1'b0;
      repeat_hit   = 1'b0;
      bits         = '0;
      kept_address = '0;
      kept_command = '0;
      mismatches   = 0;
    endfunction

    function void set_timing(cfg_reg_e idx, dur_t v);
      timing[idx] = v;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // Strict window on both sides, worked out in int so nothing wraps
    function bit fits(dur_t d, dur_t e);
      int t;
      t = int'(timing[REG_TOLERANCE]);
      return (int'(d) < int'(e) + t) && (int'(d) + t > int'(e));
    endfunction

    function bit pair_fits(dur_t m, dur_t s, cfg_reg_e rm, cfg_reg_e rs);
      return fits(m, timing[rm]) && fits(s, timing[rs]);
    endfunction

    function void note_symbol(dur_t m, dur_t s, logic last);
      frame_report_t r;
      if (count == 0) begin
        if (!pair_fits(m, s, REG_LEADER_MARK, REG_LEADER_SPACE)) fault = 1'b1;
        repeat_hit = pair_fits(m, s, REG_REPEAT_MARK, REG_REPEAT_SPACE);
      end else if (count <= DATA_BITS) begin
        // a symbol inside both windows counts as a one
        if (pair_fits(m, s, REG_BIT_MARK, REG_ONE_SPACE)) bits[count-1] = 1'b1;
        else if (pair_fits(m, s, REG_BIT_MARK, REG_ZERO_SPACE)) bits[count-1] = 1'b0;
        else fault = 1'b1;
      end
      if (count < COUNT_LIMIT) count++;
      if (!last) return;
      if (count == FULL_FRAME_SYMBOLS && !fault) begin
        kept_address = bits[HALF_BITS-1:0];
        kept_command = bits[DATA_BITS-1:HALF_BITS];
        r.kind = KIND_FULL;
      end else if (count == REPEAT_SYMBOLS && repeat_hit) begin
        r.kind = KIND_REPEAT;
      end else begin
        r.kind = KIND_REJECT;
      end
      r.address = kept_address;
      r.command = kept_command;
      frames_due.push_back(r);
      count      = 0;
      fault      = 1'b0;
      repeat_hit = 1'b0;
      bits       = '0;
    endfunction

    function void check_frame(logic [1:0] kind, logic [HALF_BITS-1:0] addr,
                              logic [HALF_BITS-1:0] cmd);
      frame_report_t want;
      if (frames_due.size() == 0) begin
        $error("unexpected frame result: frame_kind %0d address %h command %h",
               kind, addr, cmd);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      if (kind !== want.kind) begin
        $error("frame_kind: expected %0d, actual %0d", want.kind, kind);
        mismatches++;
      end
      if (addr !== want.address) begin
        $error("address: expected %h, actual %h", want.address, addr);
        mismatches++;
      end
      if (cmd !== want.command) begin
        $error("command: expected %h, actual %h", want.command, cmd);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [DW-1:0]        cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  dur_t                 mark_ticks_i  = '0;
  dur_t                 space_ticks_i = '0;
  logic                 frame_end_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [1:0]           frame_kind_o;
  logic [HALF_BITS-1:0] address_o;
  logic [HALF_BITS-1:0] command_o;

  frame_tracker sb = new();
  dur_t         cur [NUM_REGS];   // timing as last written, for shaping stimulus
  int           symbols_sent = 0;
  bit           calm         = 1'b0;  // no idling on either side
  bit           choke        = 1'b0;  // ask the receiver for one long hold-off
  bit           choked_once  = 1'b0;
  int           hold_left    = 0;

  nec_ir_frame_decoder_core uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[nec_ir_frame_decoder_core] ERROR");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request, none while calm
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (choke && !choked_once) begin
      out_stall_i <= 1'b1;
      hold_left   <= CHOKE_CYCLES;
      choked_once <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99, 0) < 11);
    end
  end

  // Sample results mid-cycle, when both the valid and our own stall are settled
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_frame(frame_kind_o, address_o, command_o);
  end

  // Offer one symbol, with an optional idle gap first; return at the accepting edge.
  task automatic send_symbol(input dur_t m, input dur_t s, input logic last);
    bit took;
    while (!calm && $urandom_range(99, 0) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mark_ticks_i  <= m;
    space_ticks_i <= s;
    frame_end_i   <= last;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    sb.note_symbol(m, s, last);
    symbols_sent++;
  endtask

  // Drop the input and hold it low until every due frame report is taken
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic settle_block();
    wait_results();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= DW'(v);
    @(posedge clk_i);
    cur[idx] = dur_t'(v);
    sb.set_timing(idx, dur_t'(v));
  endtask

  task automatic load_timing(input int lm, input int ls, input int rm, input int rs,
                             input int bm, input int zs, input int os, input int tol);
    write_reg(REG_LEADER_MARK, lm);
    write_reg(REG_LEADER_SPACE, ls);
    write_reg(REG_REPEAT_MARK, rm);
    write_reg(REG_REPEAT_SPACE, rs);
    write_reg(REG_BIT_MARK, bm);
    write_reg(REG_ZERO_SPACE, zs);
    write_reg(REG_ONE_SPACE, os);
    write_reg(REG_TOLERANCE, tol);
    cfg_we_i <= 1'b0;
  endtask

  // A duration inside the window around e, edges favoured; about one in odds
  // lands just outside it or anywhere at all.
  function automatic dur_t pick(int e, int odds);
    int t, lo, hi;
    t = int'(cur[REG_TOLERANCE]);
    if ($urandom_range(odds - 1, 0) == 0) begin
      case ($urandom_range(2, 0))
        0: if (e - t >= 0) return dur_t'(e - t);
        1: if (e + t <= DMAX) return dur_t'(e + t);
        default: ;
      endcase
      return dur_t'($urandom_range(DMAX, 0));
    end
    lo = (e - t + 1 < 0) ? 0 : e - t + 1;
    hi = (e + t - 1 > DMAX) ? DMAX : e + t - 1;
    if (lo > hi) return dur_t'(e);
    case ($urandom_range(9, 0))
      0:       return dur_t'(lo);
      1:       return dur_t'(hi);
      default: return dur_t'($urandom_range(hi, lo));
    endcase
  endfunction

  task automatic send_full_frame();
    int   i;
    logic one;
    send_symbol(pick(int'(cur[REG_LEADER_MARK]), 12),
                pick(int'(cur[REG_LEADER_SPACE]), 12), 1'b0);
    for (i = 0; i < DATA_BITS; i++) begin
      one = 1'($urandom_range(1, 0));
      send_symbol(pick(int'(cur[REG_BIT_MARK]), 80),
                  pick(int'(one ? cur[REG_ONE_SPACE] : cur[REG_ZERO_SPACE]), 80), 1'b0);
    end
    // trailing symbol carries nothing
    send_symbol(dur_t'($urandom_range(DMAX, 0)), dur_t'($urandom_range(DMAX, 0)), 1'b1);
  endtask

  task automatic send_repeat_frame();
    send_symbol(pick(int'(cur[REG_REPEAT_MARK]), 10),
                pick(int'(cur[REG_REPEAT_SPACE]), 10), 1'b0);
    send_symbol(dur_t'($urandom_range(DMAX, 0)), dur_t'($urandom_range(DMAX, 0)), 1'b1);
  endtask

  // Random lengths, mostly wrong, including runs past the count ceiling, with mixed symbols
  task automatic send_broken_frame();
    int   len, i;
    dur_t m, s;
    case ($urandom_range(5, 0))
      0:       len = 1;
      1:       len = REPEAT_SYMBOLS + 1;
      2:       len = FULL_FRAME_SYMBOLS - 1;
      3:       len = FULL_FRAME_SYMBOLS + 1;
      4:       len = $urandom_range(60, COUNT_LIMIT + 1);
      default: len = $urandom_range(40, 1);
    endcase
    for (i = 0; i < len; i++) begin
      case ($urandom_range(3, 0))
        0: begin
          m = pick(int'(cur[REG_LEADER_MARK]), 4);
          s = pick(int'(cur[REG_LEADER_SPACE]), 4);
        end
        1: begin
          m = pick(int'(cur[REG_REPEAT_MARK]), 4);
          s = pick(int'(cur[REG_REPEAT_SPACE]), 4);
        end
        2: begin
          m = pick(int'(cur[REG_BIT_MARK]), 8);
          s = pick(int'($urandom_range(1, 0) ? cur[REG_ONE_SPACE] : cur[REG_ZERO_SPACE]),
                   8);
        end
        default: begin
          m = dur_t'($urandom_range(DMAX, 0));
          s = dur_t'($urandom_range(DMAX, 0));
        end
      endcase
      send_symbol(m, s, i == len - 1);
    end
  endtask

  // Mostly well-formed frames; now and then hold off until the results are in
  task automatic run_traffic(input int budget);
    int start, roll;
    start = symbols_sent;
    while (symbols_sent - start < budget) begin
      roll = $urandom_range(99, 0);
      if (roll < 50) send_full_frame();
      else if (roll < 75) send_repeat_frame();
      else send_broken_frame();
      if ($urandom_range(29, 0) == 0) wait_results();
    end
  endtask

  initial begin
    cur[REG_LEADER_MARK]  = dur_t'(RST_LEADER_MARK);
    cur[REG_LEADER_SPACE] = dur_t'(RST_LEADER_SPACE);
    cur[REG_REPEAT_MARK]  = dur_t'(RST_REPEAT_MARK);
    cur[REG_REPEAT_SPACE] = dur_t'(RST_REPEAT_SPACE);
    cur[REG_BIT_MARK]     = dur_t'(RST_BIT_MARK);
    cur[REG_ZERO_SPACE]   = dur_t'(RST_ZERO_SPACE);
    cur[REG_ONE_SPACE]    = dur_t'(RST_ONE_SPACE);
    cur[REG_TOLERANCE]    = dur_t'(RST_TOLERANCE);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset timing
    send_symbol('0, '0, 1'b1);                                 // lone symbol, all zero
    send_symbol(dur_t'(DMAX), dur_t'(DMAX), 1'b1);             // lone symbol, all ones
    send_symbol(dur_t'(RST_REPEAT_MARK), dur_t'(RST_REPEAT_SPACE), 1'b0);
    send_symbol('0, dur_t'(DMAX), 1'b1);           // clean repeat, second symbol unchecked
    send_symbol(dur_t'(RST_REPEAT_MARK - RST_TOLERANCE + 1),
                dur_t'(RST_REPEAT_SPACE + RST_TOLERANCE - 1), 1'b0);
    send_symbol(dur_t'(DMAX), '0, 1'b1);                       // repeat on the inner edges
    send_symbol(dur_t'(RST_REPEAT_MARK - RST_TOLERANCE), dur_t'(RST_REPEAT_SPACE), 1'b0);
    send_symbol(dur_t'(RST_REPEAT_MARK), dur_t'(RST_REPEAT_SPACE), 1'b1); // mark on lower bound
    send_symbol(dur_t'(RST_REPEAT_MARK), dur_t'(RST_REPEAT_SPACE + RST_TOLERANCE), 1'b0);
    send_symbol(dur_t'(RST_REPEAT_MARK), dur_t'(RST_REPEAT_SPACE), 1'b1); // space on upper bound
    send_symbol(dur_t'(RST_LEADER_MARK), dur_t'(RST_LEADER_SPACE), 1'b0);
    send_symbol(dur_t'(RST_BIT_MARK), dur_t'(RST_ONE_SPACE), 1'b0);
    send_symbol(dur_t'(RST_BIT_MARK), dur_t'(RST_ZERO_SPACE), 1'b1); // leader, two bits: short
    send_symbol(dur_t'(RST_LEADER_MARK), dur_t'(RST_LEADER_SPACE), 1'b0);
    send_symbol(dur_t'(RST_BIT_MARK), dur_t'(RST_ONE_SPACE), 1'b1);  // two symbols, no repeat
    send_symbol(dur_t'(RST_REPEAT_MARK), dur_t'(RST_REPEAT_SPACE), 1'b0);
    send_symbol(dur_t'(RST_REPEAT_MARK), dur_t'(RST_REPEAT_SPACE), 1'b0);
    send_symbol('0, '0, 1'b1);                                 // repeat lead, one too many

    // Reset timing; receiver takes one long hold-off so the input backs up
    choke <= 1'b1;
    run_traffic(PHASE_SYMBOLS);
    settle_block();
    choke <= 1'b0;

    // Zero tolerance: nothing fits, every frame is rejected
    load_timing(RST_LEADER_MARK, RST_LEADER_SPACE, RST_REPEAT_MARK, RST_REPEAT_SPACE,
                RST_BIT_MARK, RST_ZERO_SPACE, RST_ONE_SPACE, 0);
    run_traffic(PHASE_SYMBOLS);
    settle_block();

    // Widest tolerance: every level fits, bits fall to one
    load_timing(RST_LEADER_MARK, RST_LEADER_SPACE, RST_REPEAT_MARK, RST_REPEAT_SPACE,
                RST_BIT_MARK, RST_ZERO_SPACE, RST_ONE_SPACE, DMAX);
    run_traffic(PHASE_SYMBOLS);
    settle_block();

    // All expectations zero, tolerance one: only zero-length levels fit
    load_timing(0, 0, 0, 0, 0, 0, 0, 1);
    run_traffic(PHASE_SYMBOLS);
    settle_block();

    // All expectations at the top of the range
    load_timing(DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, 300);
    run_traffic(PHASE_SYMBOLS);
    settle_block();

    // Overlapping zero and one windows; bit mark below the tolerance
    load_timing(RST_LEADER_MARK, RST_LEADER_SPACE, RST_REPEAT_MARK, RST_REPEAT_SPACE,
                100, 1000, 1100, 300);
    run_traffic(PHASE_SYMBOLS);
    settle_block();

    // Random timing
    load_timing($urandom_range(DMAX, 0), $urandom_range(DMAX, 0),
                $urandom_range(DMAX, 0), $urandom_range(DMAX, 0),
                $urandom_range(DMAX, 0), $urandom_range(DMAX, 0),
                $urandom_range(DMAX, 0), $urandom_range(1500, 1));
    run_traffic(PHASE_SYMBOLS);
    settle_block();

    // Back to the standard timing, flat out on both sides
    load_timing(RST_LEADER_MARK, RST_LEADER_SPACE, RST_REPEAT_MARK, RST_REPEAT_SPACE,
                RST_BIT_MARK, RST_ZERO_SPACE, RST_ONE_SPACE, RST_TOLERANCE);
    calm <= 1'b1;
    run_traffic(PHASE_SYMBOLS);
    settle_block();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[nec_ir_frame_decoder_core] OK");
    end else begin
      $display("[nec_ir_frame_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
